/* sv/deq_pkg.sv */
// shared types and constants for the double-ended queue
`default_nettype none

package deq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_UNDERFLOW = 2'd1,
    ERR_OVERFLOW  = 2'd2
  } err_e;

  // what one cell does with its word this cycle
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_TAKE_LEFT  = 2'd1,
    CELL_TAKE_RIGHT = 2'd2,
    CELL_LOAD       = 2'd3
  } cell_op_e;

  typedef struct packed {
    req_type_e                 req_type;
    logic signed [DATA_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  data_out;
    err_e                      error;
    logic [CNT_W-1:0]          fill_count;
    logic                      is_empty;
  } out_item_t;

endpackage

`default_nettype wire

/* sv/deq_cell.sv */
// one storage cell of the shifting deque row
`default_nettype none

module deq_cell (
  input  wire                                   clk_i,
  input  wire deq_pkg::cell_op_e                op_i,
  input  wire logic signed [deq_pkg::DATA_W-1:0] left_i,
  input  wire logic signed [deq_pkg::DATA_W-1:0] right_i,
  input  wire logic signed [deq_pkg::DATA_W-1:0] value_i,
  output logic signed [deq_pkg::DATA_W-1:0]     data_o
);

  logic signed [deq_pkg::DATA_W-1:0] data_q, data_d;

  always_comb begin
    unique case (op_i)
      deq_pkg::CELL_TAKE_LEFT:  data_d = left_i;
      deq_pkg::CELL_TAKE_RIGHT: data_d = right_i;
      deq_pkg::CELL_LOAD:       data_d = value_i;
      default:                  data_d = data_q;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

/* sv/double_ended_queue_top.sv */
// double-ended queue built as a row of shifting cells with an output register
`default_nettype none

// channel   direction  payload               handshake
// in        input      deq_pkg::in_item_t    in_valid_i / in_stall_o
// out       output     deq_pkg::out_item_t   out_valid_o / out_stall_i
//
// one item per cycle: every request is resolved in the cycle it is accepted,
// the cell row updates at that edge and the result lands in the output register
// the front word always sits in cell 0; words occupy cells 0 .. count-1
// reset clears the count and the output valid; cell contents stay undefined
// input stalls only while a finished result waits and the output side stalls

module double_ended_queue_top (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire deq_pkg::in_item_t in_item_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output deq_pkg::out_item_t  out_item_o
);

  localparam int unsigned Depth = deq_pkg::DEPTH;
  localparam int unsigned CntW  = deq_pkg::CNT_W;
  localparam int unsigned DataW = deq_pkg::DATA_W;

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  deq_pkg::out_item_t out_q, out_d;

  logic in_accept;
  logic is_full, is_empty_now;

  logic signed [DataW-1:0] cell_data [Depth];
  logic signed [DataW-1:0] back_data;
  deq_pkg::cell_op_e       cell_op   [Depth];

  // the output register drains or is empty: room for a new result
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign is_full      = (count_q == CntW'(Depth));
  assign is_empty_now = (count_q == '0);

  // tail word: the cell at count-1, picked by a one-hot or over the row
  always_comb begin
    back_data = '0;
    for (int i = 0; i < Depth; i++) begin
      back_data = back_data | ((count_q == CntW'(i + 1)) ? cell_data[i] : '0);
    end
  end

  // cell row: push front shifts toward the tail, pop front toward the head,
  // push back loads the first free cell, pop back leaves the row unchanged
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic signed [DataW-1:0] left_w, right_w;

    if (g == 0) begin : g_first
      assign left_w = in_item_i.value;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end

    if (g == Depth - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    always_comb begin
      cell_op[g] = deq_pkg::CELL_HOLD;
      if (in_accept) begin
        unique case (in_item_i.req_type)
          deq_pkg::REQ_PUSH_FRONT: begin
            if (!is_full) cell_op[g] = deq_pkg::CELL_TAKE_LEFT;
          end
          deq_pkg::REQ_PUSH_BACK: begin
            if (!is_full && count_q == CntW'(g)) cell_op[g] = deq_pkg::CELL_LOAD;
          end
          deq_pkg::REQ_POP_FRONT: begin
            if (!is_empty_now) cell_op[g] = deq_pkg::CELL_TAKE_RIGHT;
          end
          default: begin
            cell_op[g] = deq_pkg::CELL_HOLD;
          end
        endcase
      end
    end

    deq_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[g]),
      .left_i  (left_w),
      .right_i (right_w),
      .value_i (in_item_i.value),
      .data_o  (cell_data[g])
    );
  end

  // count update and result for the accepted request
  always_comb begin
    count_d        = count_q;
    out_d.data_out = '0;
    out_d.error    = deq_pkg::ERR_NONE;
    unique case (in_item_i.req_type)
      deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
        if (is_full) out_d.error = deq_pkg::ERR_OVERFLOW;
        else         count_d     = count_q + CntW'(1);
      end
      deq_pkg::REQ_POP_FRONT: begin
        if (is_empty_now) begin
          out_d.error = deq_pkg::ERR_UNDERFLOW;
        end else begin
          out_d.data_out = cell_data[0];
          count_d        = count_q - CntW'(1);
        end
      end
      default: begin
        if (is_empty_now) begin
          out_d.error = deq_pkg::ERR_UNDERFLOW;
        end else begin
          out_d.data_out = back_data;
          count_d        = count_q - CntW'(1);
        end
      end
    endcase
    out_d.fill_count = count_d;
    out_d.is_empty   = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

/* sim/double_ended_queue_top_test.sv */
// self-checking testbench for the double-ended queue: directed and random requests
`timescale 1ns / 100ps

module double_ended_queue_top_test;

  // cycles without any accepted item before the run is declared hung
  localparam int unsigned HANG_LIMIT = 2000;
  // long receiver hold-off used to back the block up into its input
  localparam int unsigned HOLD_CYCLES = 64;
  // random requests per idling phase (three phases)
  localparam int unsigned PHASE_ITEMS = 500;

  // tracks the deque contents and the results it should answer with
  class deq_scoreboard;
    logic [deq_pkg::DATA_W-1:0] words [deq_pkg::DEPTH];
    int unsigned                head = 0;
    int unsigned                count = 0;
    deq_pkg::out_item_t         expected_q [$];
    int unsigned                mismatches = 0;

    // work out the result of one accepted request and queue it
    function void note_request(deq_pkg::in_item_t req);
      deq_pkg::out_item_t res;
      int unsigned        slot;
      res = '0;
      res.error = deq_pkg::ERR_NONE;
      case (req.req_type)
        deq_pkg::REQ_PUSH_FRONT: begin
          if (count >= deq_pkg::DEPTH) begin
            res.error = deq_pkg::ERR_OVERFLOW;
          end else begin
            head = (head + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
            words[head] = req.value;
            count++;
          end
        end
        deq_pkg::REQ_PUSH_BACK: begin
          if (count >= deq_pkg::DEPTH) begin
            res.error = deq_pkg::ERR_OVERFLOW;
          end else begin
            slot = (head + count) % deq_pkg::DEPTH;
            words[slot] = req.value;
            count++;
          end
        end
        deq_pkg::REQ_POP_FRONT: begin
          if (count == 0) begin
            res.error = deq_pkg::ERR_UNDERFLOW;
          end else begin
            res.data_out = words[head];
            head = (head + 1) % deq_pkg::DEPTH;
            count--;
          end
        end
        default: begin
          if (count == 0) begin
            res.error = deq_pkg::ERR_UNDERFLOW;
          end else begin
            slot = (head + count - 1) % deq_pkg::DEPTH;
            res.data_out = words[slot];
            count--;
          end
        end
      endcase
      res.fill_count = deq_pkg::CNT_W'(count);
      res.is_empty = (count == 0);
      expected_q.insert(expected_q.size(), res);
    endfunction

    // compare one result from the block with the oldest expectation
    function void check_result(deq_pkg::out_item_t got);
      deq_pkg::out_item_t exp_item;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result data %h err %0d count %0d empty %0b", $time,
                 got.data_out, got.error, got.fill_count, got.is_empty);
        mismatches++;
        return;
      end
      exp_item = expected_q.pop_front();
      if (got.data_out !== exp_item.data_out) begin
        $display("%0t: data_out expected %h actual %h", $time,
                 exp_item.data_out, got.data_out);
        mismatches++;
      end
      if (got.error !== exp_item.error) begin
        $display("%0t: error expected %0d actual %0d", $time, exp_item.error, got.error);
        mismatches++;
      end
      if (got.fill_count !== exp_item.fill_count) begin
        $display("%0t: fill_count expected %0d actual %0d", $time,
                 exp_item.fill_count, got.fill_count);
        mismatches++;
      end
      if (got.is_empty !== exp_item.is_empty) begin
        $display("%0t: is_empty expected %0b actual %0b", $time,
                 exp_item.is_empty, got.is_empty);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  // clock, reset and block ports; the inputs are known from time zero
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  deq_pkg::in_item_t  in_item_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  deq_pkg::out_item_t out_item_o;

  // idling rates of the current phase, in percent
  int unsigned sender_idle_pct = 24;
  int unsigned receiver_stall_pct = 66;
  // raised by the stimulus to ask the receiver for one long hold-off
  bit          hold_due = 1'b0;
  int unsigned quiet_cycles = 0;

  deq_scoreboard sb;

  double_ended_queue_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  // build one request item
  function automatic deq_pkg::in_item_t make_req(deq_pkg::req_type_e kind,
                                                 logic [deq_pkg::DATA_W-1:0] word);
    deq_pkg::in_item_t req;
    req.req_type = kind;
    req.value = word;
    return req;
  endfunction

  // random request; lean picks the push share so the fill level sweeps
  // between empty and full: 0 fills, 1 drains, 2 stays balanced
  function automatic deq_pkg::in_item_t pick_request(int unsigned lean);
    int unsigned                push_pct;
    logic [deq_pkg::DATA_W-1:0] word;
    deq_pkg::req_type_e         kind;
    push_pct = (lean == 0) ? 75 : (lean == 1) ? 25 : 50;
    if ($urandom_range(0, 99) < push_pct) begin
      if ($urandom_range(0, 1) != 0) kind = deq_pkg::REQ_PUSH_BACK;
      else                           kind = deq_pkg::REQ_PUSH_FRONT;
    end else begin
      if ($urandom_range(0, 1) != 0) kind = deq_pkg::REQ_POP_BACK;
      else                           kind = deq_pkg::REQ_POP_FRONT;
    end
    // now and then an extreme word, otherwise anything
    case ($urandom_range(0, 15))
      0:       word = '0;
      1:       word = '1;
      2:       word = {1'b0, {(deq_pkg::DATA_W-1){1'b1}}};
      3:       word = {1'b1, {(deq_pkg::DATA_W-1){1'b0}}};
      default: word = $urandom;
    endcase
    return make_req(kind, word);
  endfunction

  // offer one item, with random idle cycles first, and note it once accepted
  task automatic send_request(deq_pkg::in_item_t req);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(req);
  endtask

  // receiver: random stalls at the phase rate, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_due) begin
        hold_due = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  // result monitor: every accepted result goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
  end

  // hang detection: nothing accepted on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, HANG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned        lean;
    deq_pkg::req_type_e fill_kind;
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: underflow on an empty deque from both ends
    send_request(make_req(deq_pkg::REQ_POP_FRONT, 32'h0000_0000));
    send_request(make_req(deq_pkg::REQ_POP_BACK, 32'hffff_ffff));
    // extreme words through both push kinds, popped from both ends
    send_request(make_req(deq_pkg::REQ_PUSH_FRONT, 32'h7fff_ffff));
    send_request(make_req(deq_pkg::REQ_PUSH_BACK, 32'h8000_0000));
    send_request(make_req(deq_pkg::REQ_POP_FRONT, 32'h1234_5678));
    send_request(make_req(deq_pkg::REQ_POP_BACK, 32'h0000_0000));
    // fill to capacity with mixed pushes so the head wraps below zero
    for (int i = 0; i < deq_pkg::DEPTH; i++) begin
      if (i % 2 != 0) fill_kind = deq_pkg::REQ_PUSH_BACK;
      else            fill_kind = deq_pkg::REQ_PUSH_FRONT;
      send_request(make_req(fill_kind,
                            (i % 3 == 0) ? 32'hffff_ffff : (i % 3 == 1) ? 32'h0 : $urandom));
    end
    // overflow from both ends, then take one from each end of the full deque
    send_request(make_req(deq_pkg::REQ_PUSH_FRONT, 32'hdead_beef));
    send_request(make_req(deq_pkg::REQ_PUSH_BACK, 32'hcafe_f00d));
    send_request(make_req(deq_pkg::REQ_POP_FRONT, 32'h0));
    send_request(make_req(deq_pkg::REQ_POP_BACK, 32'h0));

    // random part in three idling phases
    lean = 2;
    for (int i = 0; i < 3 * PHASE_ITEMS; i++) begin
      if (i == PHASE_ITEMS) begin
        sender_idle_pct = 66;
        receiver_stall_pct = 24;
      end
      if (i == 2 * PHASE_ITEMS) begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        // sender keeps offering while the receiver holds off
        hold_due = 1'b1;
      end
      if (i % 40 == 0) lean = $urandom_range(0, 2);
      send_request(pick_request(lean));
    end
    in_valid_i <= 1'b0;

    // drain: the watchdog covers a result that never shows up
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/deq_pkg.sv
sv/deq_cell.sv
sv/double_ended_queue_top.sv
sim/double_ended_queue_top_test.sv
